### src/lru_sector_tag_cache_assert.svh
// Assertion macros used by the checker of the sector tag cache.
`ifndef LRU_SECTOR_TAG_CACHE_ASSERT_SVH
`define LRU_SECTOR_TAG_CACHE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lstc assertion failed");

// Next-cycle implication, disabled during reset.
`define LSTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lstc assertion failed");

`endif

### src/lstc_pkg.sv
// Shared constants and types of the sector tag cache.
`default_nettype none
package lstc_pkg;
    localparam int LINES      = 64;
    localparam int LINE_W     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CNT_W      = $clog2(LINES + 1);
    localparam int CFG_W      = 7;
    localparam int HALF_W     = 16;
    localparam int KEY_W      = 2 * HALF_W;
    localparam int STAMP_W    = 64;
    localparam int OUT_DATA_W = ((LINE_W + 7) / 8) * 8;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(LINES);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic              we;
        logic [LINE_W-1:0] addr;
        logic [KEY_W-1:0]  data;
    } t_tag_wr;

    typedef struct packed {
        logic               we;
        logic [LINE_W-1:0]  addr;
        logic [STAMP_W-1:0] data;
    } t_stamp_wr;
endpackage
`default_nettype wire

### src/lstc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lstc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### src/lstc_ctrl.sv
// Lookup, fill and eviction sequencer of the sector tag cache.
`default_nettype none
module lstc_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lstc_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_op,
    input  wire logic [lstc_pkg::KEY_W-1:0]    i_key,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_out_hit,
    output logic [lstc_pkg::LINE_W-1:0]        o_out_line,
    output logic                               o_out_evict,
    input  wire logic [lstc_pkg::KEY_W-1:0]    i_tag_rdata,
    input  wire logic [lstc_pkg::STAMP_W-1:0]  i_stamp_rdata,
    output logic [lstc_pkg::LINE_W-1:0]        o_raddr,
    output lstc_pkg::t_tag_wr                  o_tag_wr,
    output lstc_pkg::t_stamp_wr                o_stamp_wr
);
    import lstc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [CNT_W-1:0]   r_fill;
    logic [STAMP_W-1:0] r_stamp;
    logic [CNT_W-1:0]   r_limit;
    logic [CNT_W-1:0]   r_issue;
    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic               r_pend;
    logic               r_pend_last;
    logic [LINE_W-1:0]  r_pend_idx;
    logic [LINE_W-1:0]  r_best_idx;
    logic [STAMP_W-1:0] r_best_stamp;
    logic               r_hit;
    logic               r_evict;
    logic [LINE_W-1:0]  r_line;
    logic               r_do_write;
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_evict;
    logic [LINE_W-1:0]  r_out_line;

    logic [CNT_W-1:0]   w_max;
    logic [CNT_W-1:0]   w_n;
    logic               w_accept;
    logic               w_match;
    logic               w_better;
    logic               w_out_free;
    logic               w_finish;

    always_comb begin
        if (r_cfg == '0) begin
            w_max = CNT_W'(1);
        end else if ({{(32-CFG_W){1'b0}}, r_cfg} > 32'(LINES)) begin
            w_max = CNT_W'(LINES);
        end else begin
            w_max = CNT_W'(r_cfg);
        end
        w_n = (r_fill < w_max) ? r_fill : w_max;
    end

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_match    = (i_tag_rdata == r_key);
    assign w_better   = (r_pend_idx == '0) || (i_stamp_rdata < r_best_stamp);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_finish   = (r_state == S_DONE) && w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;
    assign o_out_line  = r_out_line;
    assign o_out_evict = r_out_evict;
    assign o_raddr     = r_issue[LINE_W-1:0];

    assign o_tag_wr.we     = w_finish && r_do_write && (r_op == OP_INSERT);
    assign o_tag_wr.addr   = r_line;
    assign o_tag_wr.data   = r_key;
    assign o_stamp_wr.we   = w_finish && r_do_write;
    assign o_stamp_wr.addr = r_line;
    assign o_stamp_wr.data = r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET;
            r_fill      <= '0;
            r_stamp     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_op;
                        r_key   <= i_key;
                        r_issue <= '0;
                        r_pend  <= 1'b0;
                        r_hit   <= 1'b0;
                        r_evict <= 1'b0;
                        r_line  <= '0;
                        if (i_op == OP_LOOKUP) begin
                            r_do_write <= 1'b0;
                            r_limit    <= w_n;
                            r_state    <= (w_n == '0) ? S_DONE : S_SCAN;
                        end else if (r_fill < w_max) begin
                            r_do_write <= 1'b1;
                            r_line     <= r_fill[LINE_W-1:0];
                            r_fill     <= r_fill + CNT_W'(1);
                            r_state    <= S_DONE;
                        end else begin
                            r_do_write <= 1'b0;
                            r_limit    <= w_max;
                            r_state    <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue < r_limit) begin
                        r_pend      <= 1'b1;
                        r_pend_idx  <= r_issue[LINE_W-1:0];
                        r_pend_last <= (r_issue == r_limit - CNT_W'(1));
                        r_issue     <= r_issue + CNT_W'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (r_op == OP_LOOKUP) begin
                            if (w_match) begin
                                r_hit      <= 1'b1;
                                r_line     <= r_pend_idx;
                                r_do_write <= 1'b1;
                                r_pend     <= 1'b0;
                                r_state    <= S_DONE;
                            end else if (r_pend_last) begin
                                r_pend  <= 1'b0;
                                r_state <= S_DONE;
                            end
                        end else begin
                            if (w_better) begin
                                r_best_idx   <= r_pend_idx;
                                r_best_stamp <= i_stamp_rdata;
                            end
                            if (r_pend_last) begin
                                r_line     <= w_better ? r_pend_idx : r_best_idx;
                                r_evict    <= 1'b1;
                                r_do_write <= 1'b1;
                                r_pend     <= 1'b0;
                                r_state    <= S_DONE;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        r_out_line  <= r_line;
                        r_out_evict <= r_evict;
                        if (r_do_write) begin
                            r_stamp <= r_stamp + STAMP_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### src/lru_sector_tag_cache.sv
// Top level of the fully associative LRU sector tag cache.
// An insert into a free line writes without a scan; a lookup scans the filled lines in use
// until a match, and an insert into a full cache scans all lines in use for the oldest stamp.
// A new item is taken only while idle, one item at a time; the tag and stamp RAM read port sets
// the scan at one line per cycle. Reset (synchronous, active low) clears the fill count
// and stamp counter and sets lines_in_use to 64; RAM contents are not cleared.
`default_nettype none
module lru_sector_tag_cache (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lstc_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [lstc_pkg::KEY_W-1:0]          s_axis_tdata,  // track, sector
    input  wire logic                                s_axis_tuser,  // op
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [lstc_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // line
    output logic [1:0]                               m_axis_tuser   // hit, evicted
);
    import lstc_pkg::*;

    logic [KEY_W-1:0]   w_tag_rdata;
    logic [STAMP_W-1:0] w_stamp_rdata;
    logic [LINE_W-1:0]  w_raddr;
    t_tag_wr            w_tag_wr;
    t_stamp_wr          w_stamp_wr;
    logic               w_hit;
    logic               w_evict;
    logic [LINE_W-1:0]  w_line;

    lstc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_op          (s_axis_tuser),
        .i_key         (s_axis_tdata),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_hit     (w_hit),
        .o_out_line    (w_line),
        .o_out_evict   (w_evict),
        .i_tag_rdata   (w_tag_rdata),
        .i_stamp_rdata (w_stamp_rdata),
        .o_raddr       (w_raddr),
        .o_tag_wr      (w_tag_wr),
        .o_stamp_wr    (w_stamp_wr)
    );

    lstc_ram #(.WIDTH(KEY_W), .DEPTH(LINES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_wr.we),
        .i_waddr (w_tag_wr.addr),
        .i_wdata (w_tag_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_tag_rdata)
    );

    lstc_ram #(.WIDTH(STAMP_W), .DEPTH(LINES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (w_stamp_wr.we),
        .i_waddr (w_stamp_wr.addr),
        .i_wdata (w_stamp_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_stamp_rdata)
    );

    assign m_axis_tdata = OUT_DATA_W'(w_line);
    assign m_axis_tuser = {w_evict, w_hit};
endmodule
`default_nettype wire

### src/lstc_checker.sv
// Port-level assertions of the sector tag cache and their binding.
`default_nettype none
`include "lru_sector_tag_cache_assert.svh"
module lstc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [lstc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input wire logic [1:0]                         m_axis_tuser
);
    `LSTC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `LSTC_ASSERT_NOW(a_hit_evict_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]))
    `LSTC_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind lru_sector_tag_cache lstc_checker u_lstc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

### tb/tb_lru_sector_tag_cache.sv
// Testbench for the LRU sector tag cache: random and directed lookups and inserts, checked live.
`timescale 1ns / 100ps
module tb_lru_sector_tag_cache;
    import lstc_pkg::*;

    localparam int POOL = 100;

    typedef struct packed {
        logic              op;
        logic [HALF_W-1:0] track;
        logic [HALF_W-1:0] sector;
    } sector_req_t;

    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] line;
        logic              evicted;
    } line_report_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [KEY_W-1:0]      s_axis_tdata;  // track, sector
    logic                  s_axis_tuser;  // op
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;  // line
    logic [1:0]            m_axis_tuser;  // hit, evicted

    lru_sector_tag_cache i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Cache state mirror
    logic [CFG_W-1:0]   cfg_lines;
    int unsigned        fill_cnt;
    logic [STAMP_W-1:0] stamp_ctr;
    logic [HALF_W-1:0]  tag_track  [LINES];
    logic [HALF_W-1:0]  tag_sector [LINES];
    logic [STAMP_W-1:0] tag_stamp  [LINES];

    sector_req_t  pending_q[$];
    line_report_t line_reports_q[$];
    logic [KEY_W-1:0] key_pool [POOL];

    bit           idle_on;
    bit           in_taken;
    int unsigned  src_gap;
    int unsigned  sink_stall;
    int unsigned  errors;
    int unsigned  items_taken;
    int unsigned  results_seen;
    int unsigned  hits_seen;
    int unsigned  evicts_seen;
    int unsigned  settings_used;
    line_report_t want, got;

    function automatic int unsigned active_lines(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > LINES) return LINES;
        return v;
    endfunction

    function automatic line_report_t lru_access(logic op, logic [HALF_W-1:0] trk,
                                                logic [HALF_W-1:0] sct);
        line_report_t r;
        int unsigned  act;
        int unsigned  span;
        int unsigned  victim;
        r = '0;
        act = active_lines(cfg_lines);
        if (op == OP_LOOKUP) begin
            span = (fill_cnt < act) ? fill_cnt : act;
            for (int i = 0; i < span && !r.hit; i++) begin
                if (tag_track[i] == trk && tag_sector[i] == sct) begin
                    r.hit = 1'b1;
                    r.line = i[LINE_W-1:0];
                    tag_stamp[i] = stamp_ctr;
                    stamp_ctr = stamp_ctr + 1;
                end
            end
        end else begin
            if (fill_cnt >= act) begin
                victim = 0;
                for (int i = 1; i < act; i++) begin
                    if (tag_stamp[i] < tag_stamp[victim]) victim = i;
                end
                r.evicted = 1'b1;
            end else begin
                victim = fill_cnt;
                fill_cnt++;
            end
            tag_track[victim] = trk;
            tag_sector[victim] = sct;
            tag_stamp[victim] = stamp_ctr;
            stamp_ctr = stamp_ctr + 1;
            r.line = victim[LINE_W-1:0];
        end
        return r;
    endfunction

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Source side
    always @(negedge i_clk) begin : source_drive
        sector_req_t req;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                req = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {req.sector, req.track};
                s_axis_tuser <= req.op;
                if (idle_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 4);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0) sink_stall = $urandom_range(1, 4);
        end
    end

    // Accept items, predict, and check results
    always @(posedge i_clk) begin
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            line_reports_q.push_back(lru_access(s_axis_tuser, s_axis_tdata[HALF_W-1:0],
                                                s_axis_tdata[KEY_W-1:HALF_W]));
            items_taken++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit = m_axis_tuser[0];
            got.evicted = m_axis_tuser[1];
            got.line = m_axis_tdata[LINE_W-1:0];
            results_seen++;
            if (got.hit) hits_seen++;
            if (got.evicted) evicts_seen++;
            if (line_reports_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %0d: hit=%0b line=%0d evicted=%0b",
                             results_seen, got.hit, got.line, got.evicted);
            end else begin
                want = line_reports_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected hit=%0b line=%0d evicted=%0b, %s",
                                 results_seen, want.hit, want.line, want.evicted,
                                 $sformatf("got hit=%0b line=%0d evicted=%0b",
                                           got.hit, got.line, got.evicted));
                end
            end
        end
    end

    task automatic put(logic op, logic [HALF_W-1:0] trk, logic [HALF_W-1:0] sct);
        sector_req_t r;
        r.op = op;
        r.track = trk;
        r.sector = sct;
        pending_q.push_back(r);
    endtask

    task automatic write_lines(logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        cfg_lines = v;
        settings_used++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle(int unsigned tail);
        while (pending_q.size() != 0 || s_axis_tvalid || line_reports_q.size() != 0)
            @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic queue_random(int unsigned count, int unsigned act);
        sector_req_t      r;
        int unsigned      span;
        int unsigned      pick;
        logic [KEY_W-1:0] key;
        span = act + act / 2 + 2;
        if (span > POOL) span = POOL;
        repeat (count) begin
            r.op = ($urandom_range(0, 99) < 40) ? OP_INSERT : OP_LOOKUP;
            pick = $urandom_range(0, 9);
            key = key_pool[$urandom_range(0, span - 1)];
            if (pick == 8) key = key ^ (32'd1 << $urandom_range(0, KEY_W - 1));
            else if (pick == 9) key = $urandom;
            r.track = key[HALF_W-1:0];
            r.sector = key[KEY_W-1:HALF_W];
            pending_q.push_back(r);
        end
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] phase_cfg [11];
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOOKUP;
        m_axis_tready = 1'b1;
        cfg_lines = CFG_RESET;
        fill_cnt = 0;
        stamp_ctr = '0;
        idle_on = 1'b1;
        in_taken = 1'b0;
        src_gap = 0;
        sink_stall = 0;
        errors = 0;
        items_taken = 0;
        results_seen = 0;
        hits_seen = 0;
        evicts_seen = 0;
        settings_used = 0;
        for (int i = 0; i < LINES; i++) begin
            tag_track[i] = '0;
            tag_sector[i] = '0;
            tag_stamp[i] = '0;
        end
        for (int i = 0; i < POOL; i++) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
        phase_cfg = '{7'd1, 7'd64, 7'd3, 7'd0, 7'd127, 7'd9, 7'd64, 7'd2, 7'd100, 7'd31,
                      7'd64};

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty cache, key extremes, duplicate keys
        put(OP_LOOKUP, 16'h0000, 16'h0000);
        put(OP_INSERT, 16'h0000, 16'h0000);
        put(OP_INSERT, 16'hFFFF, 16'hFFFF);
        put(OP_INSERT, 16'hFFFF, 16'h0000);
        put(OP_INSERT, 16'h0000, 16'hFFFF);
        put(OP_LOOKUP, 16'hFFFF, 16'hFFFF);
        put(OP_LOOKUP, 16'h0000, 16'hFFFF);
        put(OP_LOOKUP, 16'h0000, 16'h0001);
        put(OP_INSERT, 16'h0000, 16'h0000);
        put(OP_LOOKUP, 16'h0000, 16'h0000);
        wait_idle(4);

        // Shrink below the fill level: hidden lines, eviction among the rest
        write_lines(7'd2);
        put(OP_LOOKUP, 16'h0000, 16'hFFFF);
        put(OP_INSERT, 16'h1234, 16'h5678);
        put(OP_LOOKUP, 16'hFFFF, 16'hFFFF);
        put(OP_LOOKUP, 16'h1234, 16'h5678);
        wait_idle(4);

        write_lines(7'd0);
        put(OP_INSERT, 16'hAAAA, 16'h5555);
        put(OP_LOOKUP, 16'hAAAA, 16'h5555);
        put(OP_LOOKUP, 16'h1234, 16'h5678);
        wait_idle(4);

        // Above the built size; hidden lines come back into view
        write_lines(7'd127);
        put(OP_INSERT, 16'h5555, 16'hAAAA);
        put(OP_LOOKUP, 16'h1234, 16'h5678);
        put(OP_LOOKUP, 16'h0000, 16'hFFFF);
        wait_idle(4);

        for (int p = 0; p < 11; p++) begin
            write_lines(phase_cfg[p]);
            idle_on = (p != 5 && p != 10);
            queue_random(150, active_lines(phase_cfg[p]));
            wait_idle((p == 10) ? LINES + 8 : 4);
        end

        errors += line_reports_q.size();
        $display("%0d items over %0d lines_in_use settings, %0d results checked",
                 items_taken, settings_used, results_seen);
        $display("%0d lookup hits, %0d inserts that replaced a line", hits_seen, evicts_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
